>>> hw/rtl/pkm_pkg.sv
// Shared opcodes, register offsets and reset values for the keyboard matrix port.
package pkm_pkg;

	// Transaction opcodes
	localparam logic [2:0] OP_READ     = 3'd0;
	localparam logic [2:0] OP_WRITE    = 3'd1;
	localparam logic [2:0] OP_KEY_DOWN = 3'd2;
	localparam logic [2:0] OP_KEY_UP   = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	// Register offsets
	localparam logic [1:0] OFS_PORT_A = 2'd0;
	localparam logic [1:0] OFS_CTRL_A = 2'd1;
	localparam logic [1:0] OFS_PORT_B = 2'd2;
	localparam logic [1:0] OFS_CTRL_B = 2'd3;

	// Reset values
	localparam logic [7:0] PORT_RESET = 8'hff;
	localparam logic [7:0] CTRL_RESET = 8'h80;
	localparam logic [7:0] ROW_RESET  = 8'hff;

	// Control register bit positions
	localparam int CTRL_IRQ_FLAG = 7;
	localparam int CTRL_BIT6     = 6;
	localparam int CTRL_IRQ_EN   = 0;

	// Merge a bus write into a control register: keep the flag, clear bit 6.
	function automatic logic [7:0] ctrl_merge(input logic [7:0] old, input logic [7:0] wd);
		ctrl_merge = {old[7], 1'b0, wd[5:0]};
	endfunction

endpackage

>>> hw/rtl/pia_keyboard_matrix_port.sv
// Keyboard scan port built around a simplified 6520-style peripheral adapter.
//
// Each request transaction (bus read, bus write, key down, key up, interrupt tick) is
// handled in the cycle it is accepted: the registers and the key-row store update at
// that clock edge, and exactly one response transaction (read_data, irq_pulse) is
// captured in the output register. One request is taken every clock; the only limit
// is the single output register, so req_ready drops only while a response is held and
// rsp_ready is low. rsp_valid is set in the cycle after acceptance. Port B
// reads load the key row selected by the low nibble of port A, folded into range
// through a constant lookup table. Key events naming a row at or beyond ROW_COUNT are
// dropped. A cleared bit in a row means a key is held down. All state but the response
// payload, including ROW_COUNT row bytes, is reset at once; there is no clearing pass.
module pia_keyboard_matrix_port #(
	parameter int ROW_COUNT = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  logic [2:0] opcode,
	input  logic [1:0] reg_offset,
	input  logic [7:0] write_data,
	input  logic [3:0] key_row,
	input  logic [7:0] key_mask,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output logic [7:0] read_data,
	output logic       irq_pulse
);

	localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

	// Architectural state
	logic [7:0] port_a_q;
	logic [7:0] port_b_q;
	logic [7:0] ctrl_a_q;
	logic [7:0] ctrl_b_q;
	logic [7:0] key_rows_q [ROW_COUNT];

	// Response register
	logic       rsp_valid_q;
	logic [7:0] read_data_q;
	logic       irq_pulse_q;

	logic       accept;
	logic [ROW_W-1:0] sel_tab [16];
	logic [ROW_W-1:0] scan_sel;
	logic [ROW_W-1:0] ev_idx;
	logic       ev_in_range;
	logic [7:0] scan_row;

	// Next-state values
	logic [7:0] port_a_d;
	logic [7:0] port_b_d;
	logic [7:0] ctrl_a_d;
	logic [7:0] ctrl_b_d;
	logic [7:0] data_d;
	logic       irq_d;
	logic       row_we;
	logic [7:0] row_wdata;

	// Hold the request side only while a response waits to be taken.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// Port A low nibble modulo ROW_COUNT, folded at elaboration into a table.
	for (genvar v = 0; v < 16; v++) begin : g_sel
		localparam int SEL = v % ROW_COUNT;
		assign sel_tab[v] = ROW_W'(SEL);
	end

	assign scan_sel    = sel_tab[port_a_q[3:0]];
	assign scan_row    = key_rows_q[scan_sel];
	assign ev_in_range = ({1'b0, key_row} < 5'(ROW_COUNT));
	assign ev_idx      = key_row[ROW_W-1:0];

	always_comb begin
		port_a_d  = port_a_q;
		port_b_d  = port_b_q;
		ctrl_a_d  = ctrl_a_q;
		ctrl_b_d  = ctrl_b_q;
		data_d    = 8'h00;
		irq_d     = 1'b0;
		row_we    = 1'b0;
		row_wdata = key_rows_q[ev_idx];
		case (opcode)
			pkm_pkg::OP_READ: begin
				case (reg_offset)
					pkm_pkg::OFS_PORT_A: data_d = port_a_q;
					pkm_pkg::OFS_CTRL_A: data_d = ctrl_a_q;
					pkm_pkg::OFS_PORT_B: begin
						port_b_d = scan_row;
						data_d   = scan_row;
					end
					default: data_d = ctrl_b_q;
				endcase
				// Any read acknowledges the flag of an enabled control register.
				if (ctrl_a_q[pkm_pkg::CTRL_IRQ_EN]) begin
					ctrl_a_d[pkm_pkg::CTRL_IRQ_FLAG] = 1'b0;
				end
				if (ctrl_b_q[pkm_pkg::CTRL_IRQ_EN]) begin
					ctrl_b_d[pkm_pkg::CTRL_IRQ_FLAG] = 1'b0;
				end
			end
			pkm_pkg::OP_WRITE: begin
				case (reg_offset)
					pkm_pkg::OFS_PORT_A: begin
						port_a_d = {port_a_q[7:4], write_data[3:0]};
						data_d   = port_a_d;
					end
					pkm_pkg::OFS_CTRL_A: begin
						ctrl_a_d = pkm_pkg::ctrl_merge(ctrl_a_q, write_data);
						data_d   = ctrl_a_d;
					end
					pkm_pkg::OFS_PORT_B: data_d = port_b_q;
					default: begin
						ctrl_b_d = pkm_pkg::ctrl_merge(ctrl_b_q, write_data);
						data_d   = ctrl_b_d;
					end
				endcase
			end
			pkm_pkg::OP_KEY_DOWN: begin
				row_we    = ev_in_range;
				row_wdata = key_rows_q[ev_idx] & ~key_mask;
			end
			pkm_pkg::OP_KEY_UP: begin
				row_we    = ev_in_range;
				row_wdata = key_rows_q[ev_idx] | key_mask;
			end
			pkm_pkg::OP_TICK: begin
				if (ctrl_b_q[pkm_pkg::CTRL_IRQ_EN]) begin
					ctrl_b_d[pkm_pkg::CTRL_IRQ_FLAG] = 1'b1;
					irq_d = 1'b1;
				end
			end
			default: begin
				data_d = 8'h00;
			end
		endcase
	end

	// Register state; advance only on an accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_a_q <= pkm_pkg::PORT_RESET;
			port_b_q <= pkm_pkg::PORT_RESET;
			ctrl_a_q <= pkm_pkg::CTRL_RESET;
			ctrl_b_q <= pkm_pkg::CTRL_RESET;
			for (int i = 0; i < ROW_COUNT; i++) begin
				key_rows_q[i] <= pkm_pkg::ROW_RESET;
			end
		end else if (accept) begin
			port_a_q <= port_a_d;
			port_b_q <= port_b_d;
			ctrl_a_q <= ctrl_a_d;
			ctrl_b_q <= ctrl_b_d;
			if (row_we) begin
				key_rows_q[ev_idx] <= row_wdata;
			end
		end
	end

	// Response valid: set on accept, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload needs no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= data_d;
			irq_pulse_q <= irq_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign irq_pulse = irq_pulse_q;

`ifndef NO_ASSERTIONS
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && irq_pulse_q |-> read_data_q == 8'h00)
		else $error("irq response carries nonzero data");

	a_tick_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == pkm_pkg::OP_TICK && ctrl_b_q[pkm_pkg::CTRL_IRQ_EN]
		|=> ctrl_b_q[pkm_pkg::CTRL_IRQ_FLAG] && irq_pulse_q)
		else $error("tick did not set control B flag");

	a_read_acks_a: assert property (@(posedge clk) disable iff (!arst_n)
		accept && opcode == pkm_pkg::OP_READ && ctrl_a_q[pkm_pkg::CTRL_IRQ_EN]
		|=> !ctrl_a_q[pkm_pkg::CTRL_IRQ_FLAG])
		else $error("read did not clear control A flag");

	a_bit6_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl_a_q[pkm_pkg::CTRL_BIT6] && !ctrl_b_q[pkm_pkg::CTRL_BIT6])
		else $error("control bit 6 set");

	a_port_a_high: assert property (@(posedge clk) disable iff (!arst_n)
		port_a_q[7:4] == 4'hf)
		else $error("port A high nibble changed");

	a_accept_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted request produced no response");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the keyboard matrix port: random driver, monitor and scan predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 10;
	localparam int ITEM_COUNT = 1600;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT = 500;       // results seen before the long receiver hold-off
	localparam int HOLD_CYCLES = 300;

	// Opcodes the block leaves unused; they must answer with zeros.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	// One request transaction plus the idle cycles the sender waits before offering it.
	typedef struct {
		logic [2:0] op;
		logic [1:0] ofs;
		logic [7:0] wdata;
		logic [3:0] row;
		logic [7:0] mask;
		int unsigned gap;
	} key_req_t;

	// One response transaction.
	typedef struct {
		logic [7:0] data;
		logic       irq;
	} port_rsp_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	logic [2:0] opcode;
	logic [1:0] reg_offset;
	logic [7:0] write_data;
	logic [3:0] key_row;
	logic [7:0] key_mask;
	logic       rsp_valid;
	logic       rsp_ready;
	logic [7:0] read_data;
	logic       irq_pulse;

	pia_keyboard_matrix_port #(
		.ROW_COUNT(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.opcode(opcode),
		.reg_offset(reg_offset),
		.write_data(write_data),
		.key_row(key_row),
		.key_mask(key_mask),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.read_data(read_data),
		.irq_pulse(irq_pulse)
	);

	// Requests waiting to be offered, and responses the predictor says are on their way.
	key_req_t  req_backlog[$];
	port_rsp_t rsp_owed[$];

	// Predictor copy of the adapter registers and the key-row store.
	logic [7:0] port_a_shadow;
	logic [7:0] port_b_shadow;
	logic [7:0] ctrl_a_shadow;
	logic [7:0] ctrl_b_shadow;
	logic [7:0] row_shadow[ROWS];

	int unsigned cycle_count;
	int unsigned rsp_count;
	int unsigned mismatches;

	// Handshake history from the last rising edge, consumed at the falling edge.
	logic req_taken;
	logic rsp_taken;

	// Sender and receiver pacing.
	int unsigned send_wait;
	bit          send_armed;
	key_req_t    send_item;
	int unsigned recv_wait;
	int unsigned hold_left;
	bit          hold_done;

	// Clock: 10 ns period.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycle counter and watchdog: end the run if the traffic never drains.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
		mismatches++;
		$display("mismatch at cycle %0d: %s expected %02h got %02h",
			cycle_count, what, want, got);
	endtask

	// Put the predictor back into its post-reset state.
	function automatic void clear_shadow();
		port_a_shadow = pkm_pkg::PORT_RESET;
		port_b_shadow = pkm_pkg::PORT_RESET;
		ctrl_a_shadow = pkm_pkg::CTRL_RESET;
		ctrl_b_shadow = pkm_pkg::CTRL_RESET;
		foreach (row_shadow[i])
			row_shadow[i] = pkm_pkg::ROW_RESET;
	endfunction

	function automatic logic [7:0] shadow_reg(input logic [1:0] ofs);
		case (ofs)
			pkm_pkg::OFS_PORT_A: shadow_reg = port_a_shadow;
			pkm_pkg::OFS_CTRL_A: shadow_reg = ctrl_a_shadow;
			pkm_pkg::OFS_PORT_B: shadow_reg = port_b_shadow;
			default:             shadow_reg = ctrl_b_shadow;
		endcase
	endfunction

	// Apply one accepted request to the predictor and return the response it owes.
	function automatic port_rsp_t scan_port_step(input key_req_t r);
		port_rsp_t   rsp;
		int unsigned sel;
		rsp.data = 8'h00;
		rsp.irq  = 1'b0;
		case (r.op)
			pkm_pkg::OP_READ: begin
				// A port B read first latches the row picked by port A's low nibble.
				if (r.ofs == pkm_pkg::OFS_PORT_B) begin
					sel = int'(port_a_shadow[3:0]) % ROWS;
					port_b_shadow = row_shadow[sel];
				end
				rsp.data = shadow_reg(r.ofs);
				// Acknowledge the interrupt flags only after the value is taken.
				if (ctrl_a_shadow[pkm_pkg::CTRL_IRQ_EN])
					ctrl_a_shadow[pkm_pkg::CTRL_IRQ_FLAG] = 1'b0;
				if (ctrl_b_shadow[pkm_pkg::CTRL_IRQ_EN])
					ctrl_b_shadow[pkm_pkg::CTRL_IRQ_FLAG] = 1'b0;
			end
			pkm_pkg::OP_WRITE: begin
				// Port B is read-only from the bus; control writes keep the flag, drop bit 6.
				case (r.ofs)
					pkm_pkg::OFS_PORT_A: port_a_shadow[3:0] = r.wdata[3:0];
					pkm_pkg::OFS_CTRL_A: ctrl_a_shadow[5:0] = r.wdata[5:0];
					pkm_pkg::OFS_CTRL_B: ctrl_b_shadow[5:0] = r.wdata[5:0];
					default: ;
				endcase
				if (r.ofs == pkm_pkg::OFS_CTRL_A)
					ctrl_a_shadow[pkm_pkg::CTRL_BIT6] = 1'b0;
				if (r.ofs == pkm_pkg::OFS_CTRL_B)
					ctrl_b_shadow[pkm_pkg::CTRL_BIT6] = 1'b0;
				rsp.data = shadow_reg(r.ofs);
			end
			pkm_pkg::OP_KEY_DOWN: begin
				if (r.row < ROWS)
					row_shadow[r.row] = row_shadow[r.row] & ~r.mask;
			end
			pkm_pkg::OP_KEY_UP: begin
				if (r.row < ROWS)
					row_shadow[r.row] = row_shadow[r.row] | r.mask;
			end
			pkm_pkg::OP_TICK: begin
				if (ctrl_b_shadow[pkm_pkg::CTRL_IRQ_EN]) begin
					ctrl_b_shadow[pkm_pkg::CTRL_IRQ_FLAG] = 1'b1;
					rsp.irq = 1'b1;
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	// Queue one request. Some stretches of the stream run back to back, including the
	// window around the receiver hold-off so the block fills and stalls its input.
	task automatic add_req(input logic [2:0] op, input logic [1:0] ofs, input logic [7:0] wd,
			input logic [3:0] row, input logic [7:0] mask);
		key_req_t r;
		int unsigned idx;
		idx = req_backlog.size();
		r.op = op;
		r.ofs = ofs;
		r.wdata = wd;
		r.row = row;
		r.mask = mask;
		if ((idx / 200) % 3 == 1 || (idx >= 480 && idx < 800))
			r.gap = 0;
		else
			r.gap = $urandom_range(0, 11);
		req_backlog.push_back(r);
	endtask

	// Random key row: mostly real rows, sometimes past the end of the matrix.
	function automatic logic [3:0] pick_row();
		if ($urandom_range(0, 9) == 0)
			return 4'($urandom_range(ROWS, 15));
		return 4'($urandom_range(0, ROWS - 1));
	endfunction

	// Random key mask: usually a single key, sometimes a random group.
	function automatic logic [7:0] pick_mask();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom);
		return 8'h01 << $urandom_range(0, 7);
	endfunction

	// Build the whole request stream up front.
	task automatic build_stream();
		int unsigned pick;
		logic [1:0]  ofs;
		logic [7:0]  wd;
		logic [3:0]  row;
		logic [7:0]  mask;

		// Directed opening: reset values, register extremes, row-select folding,
		// out-of-range rows, ticks with and without the enable, read acknowledge.
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_CTRL_A, 8'h00, 4'h0, 8'h00);
		// Nibble 15 folds to row 5.
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_PORT_B, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_CTRL_B, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_CTRL_A, 8'hff, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_CTRL_B, 8'h00, 4'h0, 8'h00);
		// Ignored by port B.
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_PORT_B, 8'ha5, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_KEY_DOWN, pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'hff);
		add_req(pkm_pkg::OP_KEY_DOWN, pkm_pkg::OFS_PORT_A, 8'h00, 4'(ROWS - 1), 8'h81);
		// First row past the end.
		add_req(pkm_pkg::OP_KEY_DOWN, pkm_pkg::OFS_PORT_A, 8'h00, 4'(ROWS), 8'hff);
		add_req(pkm_pkg::OP_KEY_DOWN, pkm_pkg::OFS_PORT_A, 8'h00, 4'hf, 8'hff);
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_PORT_B, 8'h00, 4'h0, 8'h00);
		// Interrupt disabled.
		add_req(pkm_pkg::OP_TICK,     pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_CTRL_B, 8'h41, 4'h0, 8'h00);
		// Interrupt fires.
		add_req(pkm_pkg::OP_TICK,     pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h00);
		// Old flag, then acknowledge.
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_CTRL_B, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_CTRL_B, 8'h00, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_KEY_UP,   pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h0f);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_PORT_A, 8'h09, 4'h0, 8'h00);
		add_req(pkm_pkg::OP_READ,     pkm_pkg::OFS_PORT_B, 8'h00, 4'h0, 8'h00);
		add_req(OP_SPARE_LO,          pkm_pkg::OFS_PORT_A, 8'h00, 4'h0, 8'h00);
		add_req(OP_SPARE_HI,          pkm_pkg::OFS_CTRL_B, 8'hff, 4'hf, 8'hff);
		add_req(pkm_pkg::OP_KEY_UP,   pkm_pkg::OFS_PORT_A, 8'h00, 4'(ROWS - 1), 8'hff);
		add_req(pkm_pkg::OP_WRITE,    pkm_pkg::OFS_PORT_A, 8'h0f, 4'h0, 8'h00);

		// Random part: scan traffic (select a row, read port B) mixed with register reads and
		// writes, key events, ticks and spare opcodes; unused fields carry random junk.
		while (req_backlog.size() < ITEM_COUNT) begin
			pick = $urandom_range(0, 99);
			ofs  = 2'($urandom);
			wd   = 8'($urandom);
			row  = pick_row();
			mask = pick_mask();
			if (pick < 20) begin
				add_req(pkm_pkg::OP_WRITE, pkm_pkg::OFS_PORT_A, wd, row, mask);
				add_req(pkm_pkg::OP_READ, pkm_pkg::OFS_PORT_B, 8'($urandom), pick_row(),
					pick_mask());
			end else if (pick < 32) begin
				add_req(pkm_pkg::OP_READ, ofs, wd, row, mask);
			end else if (pick < 44) begin
				add_req(pkm_pkg::OP_WRITE, ofs, wd, row, mask);
			end else if (pick < 64) begin
				add_req(pkm_pkg::OP_KEY_DOWN, ofs, wd, row, mask);
			end else if (pick < 80) begin
				add_req(pkm_pkg::OP_KEY_UP, ofs, wd, row, mask);
			end else if (pick < 95) begin
				add_req(pkm_pkg::OP_TICK, ofs, wd, row, mask);
			end else begin
				add_req(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), ofs, wd, row, mask);
			end
		end
	endtask

	// Driver: advance at the falling edge. Hold the current transaction until it is
	// taken, then idle for the next item's gap before presenting it.
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_taken)) begin
			if (!send_armed && req_backlog.size() != 0) begin
				send_wait = req_backlog[0].gap;
				send_armed = 1'b1;
			end
			if (send_armed && send_wait == 0) begin
				send_item = req_backlog.pop_front();
				send_armed = 1'b0;
				req_valid <= 1'b1;
				opcode <= send_item.op;
				reg_offset <= send_item.ofs;
				write_data <= send_item.wdata;
				key_row <= send_item.row;
				key_mask <= send_item.mask;
			end else begin
				req_valid <= 1'b0;
				if (send_armed)
					send_wait--;
			end
		end
	end

	// Long hold-off: once enough responses have drained, drop ready for a stretch
	// while the sender keeps pushing, so the output register fills and req_ready falls.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && rsp_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Receiver: draw a fresh stall after every taken response; every third phase of
	// the run takes responses with no stall at all.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rsp_taken)
				recv_wait = ((rsp_count / 150) % 3 == 2) ? 0 : $urandom_range(0, 11);
			if (hold_left != 0) begin
				rsp_ready <= 1'b0;
			end else if (recv_wait != 0) begin
				rsp_ready <= 1'b0;
				recv_wait--;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Monitor: at the rising edge, predict for every accepted request and check every
	// accepted response against the oldest prediction.
	always @(posedge clk) begin
		key_req_t  seen;
		port_rsp_t want;
		req_taken <= req_valid && req_ready;
		rsp_taken <= rsp_valid && rsp_ready;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				seen.op = opcode;
				seen.ofs = reg_offset;
				seen.wdata = write_data;
				seen.row = key_row;
				seen.mask = key_mask;
				seen.gap = 0;
				rsp_owed.push_back(scan_port_step(seen));
			end
			if (rsp_valid && rsp_ready) begin
				rsp_count++;
				if (rsp_owed.size() == 0) begin
					flag_mismatch("response with nothing owed, read_data", 8'h00, read_data);
				end else begin
					want = rsp_owed.pop_front();
					if (read_data !== want.data)
						flag_mismatch("read_data", want.data, read_data);
					if (irq_pulse !== want.irq)
						flag_mismatch("irq_pulse", 8'(want.irq), 8'(irq_pulse));
				end
			end
		end
	end

	// Main sequence: reset, let the stream drain, then give the verdict.
	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		opcode = pkm_pkg::OP_READ;
		reg_offset = pkm_pkg::OFS_PORT_A;
		write_data = 8'h00;
		key_row = 4'h0;
		key_mask = 8'h00;
		rsp_ready = 1'b0;
		req_taken = 1'b0;
		rsp_taken = 1'b0;
		cycle_count = 0;
		rsp_count = 0;
		mismatches = 0;
		send_wait = 0;
		send_armed = 1'b0;
		recv_wait = 0;
		hold_left = 0;
		hold_done = 1'b0;
		clear_shadow();
		build_stream();

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Wait until every request is taken and every owed response has arrived.
		while (req_backlog.size() != 0 || req_valid || rsp_owed.size() != 0)
			@(negedge clk);
		// Let the clock run on to catch any stray response.
		repeat (8) @(negedge clk);

		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
